>>> rtl/core/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared types and constants of the LED matrix PWM scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

   localparam int unsigned PIXEL_COUNT  = 576;
   localparam int unsigned MATRIX_WIDTH = 24;
   localparam int unsigned SCAN_ROWS    = 12;
   localparam int unsigned BANK_ROWS    = 8;
   localparam int unsigned COLUMN_BITS  = 48;

   localparam int unsigned ADDR_W  = $clog2(PIXEL_COUNT);
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // item kinds
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_CYCLES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_TICKS = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic write_pixel;
      logic advance;
      logic div_start;
      logic load_start;
      logic load_step;
      logic latch;
      logic emit;
   } lmps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic lit_done;
      logic blank_done;
      logic div_done;
      logic load_done;
      logic out_free;
   } lmps_status_type;

endpackage

>>> rtl/core/lmps_req_if.sv
// ----------------------------------------------------------------------------
// lmps_req_if
// Request channel: tick or pixel write beats.
// ----------------------------------------------------------------------------
interface lmps_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [9:0] pixel_index;
   logic [7:0] pixel_value;

   modport source (output valid, output mode, output pixel_index, output pixel_value,
                   input ready);
   modport sink   (input valid, input mode, input pixel_index, input pixel_value,
                   output ready);
endinterface

>>> rtl/core/lmps_rsp_if.sv
// ----------------------------------------------------------------------------
// lmps_rsp_if
// Response channel: pin state for one tick.
// ----------------------------------------------------------------------------
interface lmps_rsp_if;
   logic        valid;
   logic        ready;
   logic        output_off;
   logic [2:0]  row_address;
   logic        upper_bank_on;
   logic        lower_bank_on;
   logic [47:0] column_bits;

   modport source (output valid, output output_off, output row_address,
                   output upper_bank_on, output lower_bank_on, output column_bits,
                   input ready);
   modport sink   (input valid, input output_off, input row_address,
                   input upper_bank_on, input lower_bank_on, input column_bits,
                   output ready);
endinterface

>>> rtl/core/lmps_ctrl.sv
// ----------------------------------------------------------------------------
// lmps_ctrl
// Sequencer: frame store clear, tick phase checks, row load, response issue.
// ----------------------------------------------------------------------------
module lmps_ctrl
   import lmps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   lmps_req_if.sink        req_chan,
   input  lmps_status_type status,
   output lmps_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PHASE_END,
      ST_PHASE_START,
      ST_DIV,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == MODE_WRITE) begin
                  cmd.write_pixel = 1'b1;
               end else begin
                  state_in = ST_PHASE_END;
               end
            end
         end
         ST_PHASE_END: begin
            cmd.advance = status.lit_done;
            state_in    = ST_PHASE_START;
         end
         ST_PHASE_START: begin
            if (status.blank_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.load_start = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (status.load_done) begin
               cmd.latch = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // a tick never ends without exactly one response issue
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.out_free) |=> (state_ff == ST_IDLE))
      else $error("emit did not return to idle");

   // no beat is taken while the frame store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_chan.ready)
      else $error("request taken during clear");

   // the row load only starts once the quotient is settled
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_start |-> status.div_done)
      else $error("row load before division finished");

endmodule

>>> rtl/core/lmps_dpath.sv
// ----------------------------------------------------------------------------
// lmps_dpath
// Datapath: registers, frame store, threshold divider, column shifter and
// response register.
// ----------------------------------------------------------------------------
module lmps_dpath
   import lmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [9:0]            pixel_index,
   input  logic [7:0]            pixel_value,
   input  lmps_cmd_type          cmd,
   output lmps_status_type       status,
   lmps_rsp_if.source            rsp_chan
);

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(PIXEL_COUNT - 1);
   localparam logic [ADDR_W-1:0] HALF_JUMP   = ADDR_W'(11 * MATRIX_WIDTH + 1);
   localparam logic [5:0]        HALF_BIT    = 6'(MATRIX_WIDTH - 1);
   localparam logic [5:0]        LOAD_BITS   = 6'(COLUMN_BITS);
   localparam logic [3:0]        LAST_ROW    = 4'(SCAN_ROWS - 1);
   localparam logic [3:0]        BANK_ROWS_C = 4'(BANK_ROWS);

   // configuration
   logic [8:0]  pwm_cycles_ff;
   logic [15:0] hold_ticks_ff;
   logic [15:0] blank_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_cycles_ff  <= 9'd32;
         hold_ticks_ff  <= 16'd4096;
         blank_ticks_ff <= 16'd1024;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PWM_CYCLES:  pwm_cycles_ff  <= csr_wdata[8:0];
            CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata;
            CSR_BLANK_TICKS: blank_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [8:0] eff_cycles;
   always_comb begin
      if (pwm_cycles_ff == 9'd0) begin
         eff_cycles = 9'd1;
      end else if (pwm_cycles_ff > 9'd256) begin
         eff_cycles = 9'd256;
      end else begin
         eff_cycles = pwm_cycles_ff;
      end
   end

   // scan state
   logic        lit_ff;
   logic [15:0] wait_ff;
   logic [3:0]  row_ff;
   logic [7:0]  step_ff;
   logic [47:0] columns_ff;
   logic [2:0]  latched_row_ff;
   logic [47:0] shift_ff;
   logic [8:0]  step_inc;

   assign step_inc = {1'b0, step_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff         <= 1'b0;
         wait_ff        <= '0;
         row_ff         <= '0;
         step_ff        <= '0;
         columns_ff     <= '0;
         latched_row_ff <= '0;
      end else begin
         if (cmd.advance) begin
            lit_ff  <= 1'b0;
            wait_ff <= '0;
            if (row_ff == LAST_ROW) begin
               row_ff  <= '0;
               step_ff <= (step_inc >= eff_cycles) ? 8'd0 : step_inc[7:0];
            end else begin
               row_ff <= row_ff + 4'd1;
            end
         end else if (cmd.latch) begin
            lit_ff         <= 1'b1;
            wait_ff        <= '0;
            columns_ff     <= shift_ff;
            latched_row_ff <= row_ff[2:0];
         end else if (cmd.emit && wait_ff != 16'hFFFF) begin
            wait_ff <= wait_ff + 16'd1;
         end
      end
   end

   // threshold divider: step*255 / cycles, one quotient bit a cycle
   logic [15:0] quo_ff;
   logic [8:0]  rem_ff;
   logic [4:0]  div_cnt_ff;
   logic [9:0]  trial;
   logic [7:0]  threshold;

   assign trial = {rem_ff, quo_ff[15]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= 5'd16;
      end else if (div_cnt_ff != 5'd0) begin
         div_cnt_ff <= div_cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= {step_ff, 8'd0} - 16'(step_ff);
         rem_ff <= '0;
      end else if (div_cnt_ff != 5'd0) begin
         if (trial >= {1'b0, eff_cycles}) begin
            rem_ff <= 9'(trial - {1'b0, eff_cycles});
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= trial[8:0];
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
   end

   // wraps modulo 256 when the step is stale
   assign threshold = 8'hFF - quo_ff[7:0];

   // frame store with clearing pass after reset
   logic [7:0]        mem [PIXEL_COUNT];
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [7:0]        rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear && clr_addr_ff != LAST_ADDR) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = 8'd0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.write_pixel && pixel_index < 10'(PIXEL_COUNT)) begin
         wr_en   = 1'b1;
         wr_addr = pixel_index[ADDR_W-1:0];
         wr_data = pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   // row load: one pixel read a beat, compared in the cycle after the read
   logic [5:0] bit_cnt_ff;
   logic       rd_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= LOAD_BITS;
         rd_pend_ff <= 1'b0;
      end else if (cmd.load_start) begin
         bit_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else if (cmd.load_step) begin
         rd_pend_ff <= (bit_cnt_ff != LOAD_BITS);
         if (bit_cnt_ff != LOAD_BITS) begin
            bit_cnt_ff <= bit_cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         rd_addr_ff <= ADDR_W'({row_ff, 4'b0}) + ADDR_W'({row_ff, 3'b0});
      end else if (cmd.load_step && bit_cnt_ff != LOAD_BITS) begin
         // bottom half sits twelve rows further on
         rd_addr_ff <= (bit_cnt_ff == HALF_BIT) ? rd_addr_ff + HALF_JUMP
                                                : rd_addr_ff + ADDR_W'(1);
      end
      if (cmd.load_step && rd_pend_ff) begin
         shift_ff <= {(rd_data_ff >= threshold), shift_ff[47:1]};
      end
   end

   // response register
   logic        rsp_valid_ff;
   logic        off_ff;
   logic [2:0]  out_row_ff;
   logic        upper_ff;
   logic        lower_ff;
   logic [47:0] out_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         off_ff      <= !lit_ff;
         out_row_ff  <= latched_row_ff;
         upper_ff    <= lit_ff && (row_ff < BANK_ROWS_C);
         lower_ff    <= lit_ff && (row_ff >= BANK_ROWS_C);
         out_cols_ff <= columns_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.output_off    = off_ff;
   assign rsp_chan.row_address   = out_row_ff;
   assign rsp_chan.upper_bank_on = upper_ff;
   assign rsp_chan.lower_bank_on = lower_ff;
   assign rsp_chan.column_bits   = out_cols_ff;

   always_comb begin
      status            = '0;
      status.clear_last = (clr_addr_ff == LAST_ADDR);
      status.lit_done   = lit_ff && (wait_ff >= hold_ticks_ff);
      status.blank_done = !lit_ff && (wait_ff >= blank_ticks_ff);
      status.div_done   = (div_cnt_ff == 5'd0);
      status.load_done  = (bit_cnt_ff == LOAD_BITS) && !rd_pend_ff;
      status.out_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   // blanked beats light no bank, lit beats exactly one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((off_ff ^ (upper_ff | lower_ff)) && !(upper_ff && lower_ff)))
      else $error("bank enables disagree with blanking");

   assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW)
      else $error("scan row out of range");

   // a saturated wait count only leaves saturation through a phase change
   assert property (@(posedge clock) disable iff (reset)
      (wait_ff == 16'hFFFF) |=> (wait_ff == 16'hFFFF || wait_ff == 16'd0))
      else $error("wait count wrapped");

   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && cmd.load_step))
      else $error("frame store written during row load");

endmodule

>>> rtl/core/led_matrix_pwm_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner
// Multiplexed row scan with threshold PWM for a 24x24 LED matrix.
// ----------------------------------------------------------------------------
// After reset the frame store is cleared one pixel a cycle, so no beat is
// taken until the clearing pass is done. A pixel write gives no response. A
// tick that loads no row passes the phase end, phase start and emit states; a
// tick that ends blanking and loads a row also runs the bit-serial division
// for the PWM threshold and the 48 reads of the frame store's single read
// port. The response sits in an output register, and pixel writes are still
// taken while it waits to be collected.
module led_matrix_pwm_scanner
   import lmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   lmps_req_if.sink              req_chan,
   lmps_rsp_if.source            rsp_chan
);

   lmps_cmd_type    cmd;
   lmps_status_type status;

   lmps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .status   (status),
      .cmd      (cmd)
   );

   lmps_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pixel_index (req_chan.pixel_index),
      .pixel_value (req_chan.pixel_value),
      .cmd         (cmd),
      .status      (status),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix PWM scanner: pixel writes and scan
// ticks go in over the request channel, and every pin-state beat that comes
// back is checked against a cycle-free model of the scan held in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import lmps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned RANDOM_BEATS = 500;
   localparam int unsigned PHASE_BEATS  = 50;

   typedef struct packed {
      logic       mode;
      logic [9:0] pixel_index;
      logic [7:0] pixel_value;
   } req_beat_type;

   typedef struct packed {
      logic        output_off;
      logic [2:0]  row_address;
      logic        upper_bank_on;
      logic        lower_bank_on;
      logic [47:0] column_bits;
   } pin_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lmps_req_if req_bus ();
   lmps_rsp_if rsp_bus ();

   led_matrix_pwm_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #1 clock = ~clock;

   // scan model state and its copy of the registers
   logic [8:0]  pwm_cycles_reg;
   logic [15:0] hold_ticks_reg;
   logic [15:0] blank_ticks_reg;
   logic [7:0]  frame_copy [PIXEL_COUNT];
   logic        lit;
   logic [15:0] phase_ticks;
   logic [3:0]  scan_row;
   logic [7:0]  pwm_step;
   logic [47:0] row_columns;
   logic [2:0]  row_latched;

   req_beat_type  beat_queue [$];
   pin_state_type pins_due [$];
   int unsigned   beats_queued = 0;
   int unsigned   beats_accepted = 0;
   int unsigned   req_idle_pct = 33;
   int unsigned   rsp_idle_pct = 33;
   int unsigned   rsp_hold_left = 0;
   int unsigned   cycle_count = 0;
   logic          req_taken = 1'b0;
   logic          failed = 1'b0;
   req_beat_type  next_beat;
   pin_state_type seen_pins;
   pin_state_type want_pins;

   function automatic int steps_in_sequence();
      if (pwm_cycles_reg == 9'd0) return 1;
      if (pwm_cycles_reg > 9'd256) return 256;
      return int'(pwm_cycles_reg);
   endfunction

   function automatic void apply_req_beat(req_beat_type beat);
      pin_state_type pins;
      logic [7:0]    level;
      int unsigned   src;
      int            next_step;
      if (beat.mode == MODE_WRITE) begin
         if (beat.pixel_index < PIXEL_COUNT)
            frame_copy[beat.pixel_index] = beat.pixel_value;
         return;
      end
      if (lit && phase_ticks >= hold_ticks_reg) begin
         scan_row = scan_row + 4'd1;
         if (scan_row >= SCAN_ROWS) begin
            scan_row = 4'd0;
            next_step = int'(pwm_step) + 1;
            pwm_step = (next_step >= steps_in_sequence()) ? 8'd0 : 8'(next_step);
         end
         lit = 1'b0;
         phase_ticks = 16'd0;
      end
      if (!lit && phase_ticks >= blank_ticks_reg) begin
         // a stale step gives a negative threshold, kept modulo 256
         level = 8'(255 - (int'(pwm_step) * 255) / steps_in_sequence());
         for (int b = 0; b < COLUMN_BITS; b++) begin
            src = ((b < 24) ? int'(scan_row) : int'(scan_row) + SCAN_ROWS) * MATRIX_WIDTH
                  + (b % 24);
            row_columns[b] = (frame_copy[src] >= level);
         end
         row_latched = 3'(scan_row % BANK_ROWS);
         lit = 1'b1;
         phase_ticks = 16'd0;
      end
      pins.output_off    = !lit;
      pins.row_address   = row_latched;
      pins.upper_bank_on = lit && (scan_row < BANK_ROWS);
      pins.lower_bank_on = lit && (scan_row >= BANK_ROWS);
      pins.column_bits   = row_columns;
      pins_due.push_back(pins);
      if (phase_ticks != 16'hFFFF) phase_ticks = phase_ticks + 16'd1;
   endfunction

   task automatic queue_beat(logic mode, logic [9:0] index, logic [7:0] value);
      beat_queue.push_back('{mode: mode, pixel_index: index, pixel_value: value});
      beats_queued++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_PWM_CYCLES:  pwm_cycles_reg  = data[8:0];
         CSR_HOLD_TICKS:  hold_ticks_reg  = data;
         CSR_BLANK_TICKS: blank_ticks_reg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // every beat taken and answered, then room for a trailing pixel write
   task automatic settle();
      while (beats_accepted != beats_queued || pins_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         if (beat_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_beat = beat_queue.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.mode        <= next_beat.mode;
            req_bus.pixel_index <= next_beat.pixel_index;
            req_bus.pixel_value <= next_beat.pixel_value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // monitor: check the response beat first, then model the request beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_pins.output_off    = rsp_bus.output_off;
            seen_pins.row_address   = rsp_bus.row_address;
            seen_pins.upper_bank_on = rsp_bus.upper_bank_on;
            seen_pins.lower_bank_on = rsp_bus.lower_bank_on;
            seen_pins.column_bits   = rsp_bus.column_bits;
            if (pins_due.size() == 0) begin
               $error("pin state beat with none expected: %h", seen_pins);
               failed = 1'b1;
            end else begin
               want_pins = pins_due.pop_front();
               if (seen_pins.output_off !== want_pins.output_off) begin
                  $error("output_off: expected %0d, got %0d",
                         want_pins.output_off, seen_pins.output_off);
                  failed = 1'b1;
               end
               if (seen_pins.row_address !== want_pins.row_address) begin
                  $error("row_address: expected %0d, got %0d",
                         want_pins.row_address, seen_pins.row_address);
                  failed = 1'b1;
               end
               if (seen_pins.upper_bank_on !== want_pins.upper_bank_on) begin
                  $error("upper_bank_on: expected %0d, got %0d",
                         want_pins.upper_bank_on, seen_pins.upper_bank_on);
                  failed = 1'b1;
               end
               if (seen_pins.lower_bank_on !== want_pins.lower_bank_on) begin
                  $error("lower_bank_on: expected %0d, got %0d",
                         want_pins.lower_bank_on, seen_pins.lower_bank_on);
                  failed = 1'b1;
               end
               if (seen_pins.column_bits !== want_pins.column_bits) begin
                  $error("column_bits: expected %h, got %h",
                         want_pins.column_bits, seen_pins.column_bits);
                  failed = 1'b1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            apply_req_beat('{mode: req_bus.mode, pixel_index: req_bus.pixel_index,
                             pixel_value: req_bus.pixel_value});
            beats_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned     random_beats;
      int unsigned     phase_no;
      logic [8:0]      pwm_pick;
      logic [15:0]     hold_pick;
      logic [15:0]     blank_pick;
      logic [9:0]      index_pick;
      logic [7:0]      value_pick;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_TICK;
      req_bus.pixel_index = '0;
      req_bus.pixel_value = '0;
      rsp_bus.ready       = 1'b0;
      pwm_cycles_reg  = 9'd32;
      hold_ticks_reg  = 16'd4096;
      blank_ticks_reg = 16'd1024;
      for (int i = 0; i < PIXEL_COUNT; i++) frame_copy[i] = 8'd0;
      lit         = 1'b0;
      phase_ticks = 16'd0;
      scan_row    = 4'd0;
      pwm_step    = 8'd0;
      row_columns = '0;
      row_latched = 3'd0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: output stays blanked on the cleared store
      queue_beat(MODE_TICK, 10'd0, 8'd0);
      queue_beat(MODE_WRITE, 10'd0, 8'd255);
      queue_beat(MODE_WRITE, 10'd575, 8'd255);
      queue_beat(MODE_WRITE, 10'd1023, 8'd0);    // beyond the store, dropped
      queue_beat(MODE_WRITE, 10'd576, 8'd255);   // first index out of range
      queue_beat(MODE_WRITE, 10'd300, 8'd254);   // just below full-on threshold
      queue_beat(MODE_WRITE, 10'd23, 8'd255);
      queue_beat(MODE_TICK, 10'd0, 8'd0);
      settle();

      // zero cycles acts as one, zero-length phases: one row per tick
      write_reg(CSR_PWM_CYCLES, 16'd0);
      write_reg(CSR_HOLD_TICKS, 16'd0);
      write_reg(CSR_BLANK_TICKS, 16'd0);
      write_reg(CSR_SPARE, 16'hFFFF);
      repeat (13) queue_beat(MODE_TICK, 10'd0, 8'd0);
      settle();

      phase_no = 0;
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         case (phase_no)
            0: begin pwm_pick = 9'd4;   hold_pick = 16'd0;     blank_pick = 16'd0;     end
            1: begin pwm_pick = 9'd256; hold_pick = 16'd1;     blank_pick = 16'd2;     end
            2: begin pwm_pick = 9'd2;   hold_pick = 16'd0;     blank_pick = 16'd1;     end
            3: begin pwm_pick = 9'd511; hold_pick = 16'hFFFF;  blank_pick = 16'd0;     end
            4: begin pwm_pick = 9'd3;   hold_pick = 16'd2;     blank_pick = 16'hFFFF;  end
            default: begin
               pwm_pick = ($urandom_range(3) != 0) ? 9'($urandom_range(8, 1))
                                                   : 9'($urandom_range(511));
               hold_pick  = ($urandom_range(4) != 0) ? 16'($urandom_range(3))
                                                     : 16'($urandom_range(40));
               blank_pick = ($urandom_range(4) != 0) ? 16'($urandom_range(3))
                                                     : 16'($urandom_range(40));
            end
         endcase
         // junk above the cycle count field must be dropped
         write_reg(CSR_PWM_CYCLES, {7'($urandom_range(127)), pwm_pick});
         write_reg(CSR_HOLD_TICKS, hold_pick);
         write_reg(CSR_BLANK_TICKS, blank_pick);
         req_idle_pct = (phase_no == 0) ? 0 : 33;
         rsp_idle_pct = (phase_no == 0) ? 0 : 33;
         if (phase_no == 2) rsp_hold_left = 400;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if ($urandom_range(99) < 70) begin
               queue_beat(MODE_TICK, 10'($urandom_range(1023)), 8'($urandom_range(255)));
            end else begin
               index_pick = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 576))
                                                     : 10'($urandom_range(575));
               if ($urandom_range(3) == 0)
                  value_pick = $urandom_range(1) ? 8'hFF : 8'h00;
               else
                  value_pick = 8'($urandom_range(255));
               queue_beat(MODE_WRITE, index_pick, value_pick);
            end
         end
         random_beats += PHASE_BEATS;
         settle();
         phase_no++;
      end

      if (!failed) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
